### rtl/pmic_seq_pkg.sv
// Shared definitions for the PMIC power sequencer: widths, command codes,
// register indexes, fixed delays and register reset values.
// No dependencies.
package pmic_seq_pkg;

  // Timer and register widths
  localparam int TIMER_BITS = 13;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  // Command codes carried in func
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_PWR_ON = 2'd1;
  localparam logic [1:0] FUNC_RESET  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PON_CHECK_EN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PON_ACT_LVL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_ACT_LVL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_PON_TO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TO       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_DELAY   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_PON_TO  = 3'd6;

  // Fixed delays in ticks
  localparam logic [CMP_W-1:0] ON_DELAY_MS = CMP_W'(65);
  localparam logic [CMP_W-1:0] TAIL_MS     = CMP_W'(10);

  // Register reset values
  localparam logic [CFG_W-1:0] BOOT_PON_DEFAULT    = CFG_W'(100);
  localparam logic [CFG_W-1:0] HOLD_DEFAULT        = CFG_W'(240);
  localparam logic [CFG_W-1:0] RESET_DELAY_DEFAULT = CFG_W'(3000);
  localparam logic [CFG_W-1:0] RESET_PON_DEFAULT   = CFG_W'(1650);

  // Saturating timer maximum
  localparam logic [TIMER_BITS-1:0] ELAPSED_MAX = {TIMER_BITS{1'b1}};

endpackage

### rtl/pmic_power_sequencer_core.sv
// PMIC power sequencer: input register, sequencing state machine with a
// saturating millisecond counter, and result register.
// Depends on pmic_seq_pkg.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------
//  in      | in_func, in_pon_level, in_hold_level    | in_valid/in_ready
//  out     | out_keypad_power_on, out_reset_in_on,   | out_valid/out_ready
//          | out_busy_res, out_finished, out_succeeded |
//  cfg     | cfg_index, cfg_wdata                    | cfg_we, no wait
//
// One beat per cycle is sustained while out_ready is high; a beat is held
// in the input register and then leaves through the result register.
// The sequencer state advances as a beat moves from input to result register.
// Reset (synchronous, active low) returns to idle with the default registers.
// A stall on out_ready backs up through both registers to in_ready.
module pmic_power_sequencer_core
  import pmic_seq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_func,
  input  logic                 in_pon_level,
  input  logic                 in_hold_level,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_keypad_power_on,
  output logic                 out_reset_in_on,
  output logic                 out_busy_res,
  output logic                 out_finished,
  output logic                 out_succeeded,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Phase codes
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_ON_DELAY  = 3'd1;
  localparam logic [2:0] PH_ON_PON    = 3'd2;
  localparam logic [2:0] PH_ON_HOLD   = 3'd3;
  localparam logic [2:0] PH_ON_TAIL   = 3'd4;
  localparam logic [2:0] PH_RST_DELAY = 3'd5;
  localparam logic [2:0] PH_RST_PON   = 3'd6;

  // Configuration registers
  logic             pon_check_en_r;
  logic             pon_act_lvl_r;
  logic             hold_act_lvl_r;
  logic [CFG_W-1:0] boot_pon_to_r;
  logic [CFG_W-1:0] hold_to_r;
  logic [CFG_W-1:0] reset_delay_r;
  logic [CFG_W-1:0] reset_pon_to_r;

  // Input register
  logic       s1_valid_r;
  logic [1:0] s1_func_r;
  logic       s1_pon_r;
  logic       s1_hold_r;

  // Sequencer state
  logic [2:0]            phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic                  ok_r, ok_nxt;
  logic                  kp_r, kp_nxt;
  logic                  rs_r, rs_nxt;
  logic                  done_nxt;

  // Result register
  logic out_valid_r;
  logic out_kp_r, out_rs_r, out_busy_r, out_fin_r, out_ok_r;

  logic s2_free;
  logic s1_adv;
  logic pon_met, hold_met, pon_skip;
  logic [CMP_W-1:0] el_cmp, inc_cmp;

  // Handshake: the input register moves on whenever the result register frees
  assign s2_free  = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s2_free;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pon_check_en_r <= 1'b1;
      pon_act_lvl_r  <= 1'b1;
      hold_act_lvl_r <= 1'b1;
      boot_pon_to_r  <= BOOT_PON_DEFAULT;
      hold_to_r      <= HOLD_DEFAULT;
      reset_delay_r  <= RESET_DELAY_DEFAULT;
      reset_pon_to_r <= RESET_PON_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PON_CHECK_EN: pon_check_en_r <= cfg_wdata[0];
        REG_PON_ACT_LVL:  pon_act_lvl_r  <= cfg_wdata[0];
        REG_HOLD_ACT_LVL: hold_act_lvl_r <= cfg_wdata[0];
        REG_BOOT_PON_TO:  boot_pon_to_r  <= cfg_wdata;
        REG_HOLD_TO:      hold_to_r      <= cfg_wdata;
        REG_RESET_DELAY:  reset_delay_r  <= cfg_wdata;
        REG_RESET_PON_TO: reset_pon_to_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture the incoming beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_func_r <= in_func;
      s1_pon_r  <= in_pon_level;
      s1_hold_r <= in_hold_level;
    end
  end

  // Saturating count and pin checks
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign el_cmp      = CMP_W'(elapsed_r);
  assign inc_cmp     = CMP_W'(elapsed_inc);
  assign pon_met     = (s1_pon_r == pon_act_lvl_r);
  assign hold_met    = (s1_hold_r == hold_act_lvl_r);
  assign pon_skip    = !pon_check_en_r || pon_met;

  // Advance the sequencer by one beat
  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    ok_nxt      = ok_r;
    kp_nxt      = kp_r;
    rs_nxt      = rs_r;
    done_nxt    = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (s1_func_r == FUNC_PWR_ON) begin
        ok_nxt      = 1'b1;
        rs_nxt      = 1'b0;
        kp_nxt      = 1'b1;
        phase_nxt   = PH_ON_DELAY;
        elapsed_nxt = '0;
      end else if (s1_func_r == FUNC_RESET) begin
        ok_nxt      = 1'b1;
        rs_nxt      = 1'b1;
        phase_nxt   = PH_RST_DELAY;
        elapsed_nxt = '0;
      end
    end else if (s1_func_r == FUNC_TICK) begin
      case (phase_r)
        PH_ON_DELAY: begin
          elapsed_nxt = elapsed_inc;
          if (inc_cmp >= ON_DELAY_MS) begin
            elapsed_nxt = '0;
            if (!pon_skip) begin
              phase_nxt = PH_ON_PON;
            end else if (hold_met) begin
              phase_nxt = PH_ON_TAIL;
            end else begin
              phase_nxt = PH_ON_HOLD;
            end
          end
        end
        PH_ON_PON: begin
          if (el_cmp >= CMP_W'(boot_pon_to_r)) begin
            ok_nxt      = 1'b0;
            phase_nxt   = PH_ON_TAIL;
            elapsed_nxt = '0;
          end else if (pon_met) begin
            phase_nxt   = hold_met ? PH_ON_TAIL : PH_ON_HOLD;
            elapsed_nxt = '0;
          end else begin
            elapsed_nxt = elapsed_inc;
          end
        end
        PH_ON_HOLD: begin
          if (el_cmp >= CMP_W'(hold_to_r)) begin
            ok_nxt      = 1'b0;
            phase_nxt   = PH_ON_TAIL;
            elapsed_nxt = '0;
          end else if (hold_met) begin
            phase_nxt   = PH_ON_TAIL;
            elapsed_nxt = '0;
          end else begin
            elapsed_nxt = elapsed_inc;
          end
        end
        PH_ON_TAIL: begin
          elapsed_nxt = elapsed_inc;
          if (inc_cmp >= TAIL_MS) begin
            kp_nxt      = 1'b0;
            phase_nxt   = PH_IDLE;
            elapsed_nxt = '0;
            done_nxt    = 1'b1;
          end
        end
        PH_RST_DELAY: begin
          elapsed_nxt = elapsed_inc;
          if (inc_cmp >= CMP_W'(reset_delay_r)) begin
            elapsed_nxt = '0;
            if (pon_skip) begin
              rs_nxt    = 1'b0;
              phase_nxt = PH_IDLE;
              done_nxt  = 1'b1;
            end else begin
              phase_nxt = PH_RST_PON;
            end
          end
        end
        PH_RST_PON: begin
          if (el_cmp >= CMP_W'(reset_pon_to_r)) begin
            ok_nxt      = 1'b0;
            rs_nxt      = 1'b0;
            phase_nxt   = PH_IDLE;
            elapsed_nxt = '0;
            done_nxt    = 1'b1;
          end else if (pon_met) begin
            rs_nxt      = 1'b0;
            phase_nxt   = PH_IDLE;
            elapsed_nxt = '0;
            done_nxt    = 1'b1;
          end else begin
            elapsed_nxt = elapsed_inc;
          end
        end
        default: begin
          phase_nxt   = PH_IDLE;
          elapsed_nxt = '0;
        end
      endcase
    end
  end

  // Commit the state as the beat moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      elapsed_r <= '0;
      ok_r      <= 1'b1;
      kp_r      <= 1'b0;
      rs_r      <= 1'b0;
    end else if (s1_adv) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      ok_r      <= ok_nxt;
      kp_r      <= kp_nxt;
      rs_r      <= rs_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_kp_r   <= kp_nxt;
      out_rs_r   <= rs_nxt;
      out_busy_r <= (phase_nxt != PH_IDLE);
      out_fin_r  <= done_nxt;
      out_ok_r   <= ok_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_keypad_power_on = out_kp_r;
  assign out_reset_in_on     = out_rs_r;
  assign out_busy_res        = out_busy_r;
  assign out_finished        = out_fin_r;
  assign out_succeeded       = out_ok_r;

  // Keypad power and reset-in are never driven together
  a_lines_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(kp_r && rs_r))
    else $error("keypad power and reset-in both asserted");

  // A running sequence always holds one of its lines
  a_busy_line: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (kp_r || rs_r))
    else $error("sequence running with no line asserted");

  // A finishing beat reports idle
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_finished) |-> !out_busy_res)
    else $error("finished beat still busy");

  // Back-pressure only while the input register is occupied
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");

endmodule
